// File: src/abad_pkg.sv
// Shared types, address map constants and decode helpers for the bus address decoder.
package abad_pkg;

  localparam int RAM_BYTES        = 2048;
  localparam int SPRITE_RAM_BYTES = 64;
  localparam int ROW_W            = $clog2(RAM_BYTES);
  localparam int SPR_W            = $clog2(SPRITE_RAM_BYTES);
  localparam int LANES            = 4;

  localparam logic [15:0] ADDR_ROM_TOP      = 16'hC000;
  localparam logic [15:0] ADDR_SOUND_INDEX  = 16'hD000;
  localparam logic [15:0] ADDR_SOUND_DATA   = 16'hD001;
  localparam logic [15:0] ADDR_CONTROL      = 16'hD008;
  localparam logic [15:0] ADDR_SYSTEM       = 16'hD00C;
  localparam logic [15:0] ADDR_FIRE         = 16'hD010;
  localparam logic [15:0] ADDR_PADDLE       = 16'hD018;
  localparam logic [15:0] ADDR_EXTRA_BASE   = 16'hE840;
  localparam logic [15:0] ADDR_EXTRA_LAST   = 16'hEFFF;
  localparam logic [15:0] ADDR_ZERO_A       = 16'hF000;
  localparam logic [15:0] ADDR_ZERO_B       = 16'hF002;

  localparam logic [4:0] WORK_PAGE   = 5'b11000;
  localparam logic [4:0] VIDEO_PAGE  = 5'b11100;
  localparam logic [9:0] SPRITE_PAGE = 10'h3A0;

  localparam logic [3:0] SOUND_PORT_FIRST = 4'hE;
  localparam logic [7:0] OPEN_BUS         = 8'hFF;
  localparam logic [7:0] SYSTEM_IDLE      = 8'h4F;

  // register index, taken from paddr[2]
  localparam logic CFG_DIP_SWITCHES = 1'b0;

  typedef enum logic [1:0] {
    LANE_WORK,
    LANE_VIDEO,
    LANE_EXTRA,
    LANE_SPRITE
  } lane_t;

  typedef struct packed {
    logic             rd;
    logic             wr;
    logic [ROW_W-1:0] row;
    lane_t            lane;
    logic [7:0]       data;
  } mem_req_t;

  typedef struct packed {
    logic             hit;
    lane_t            lane;
    logic [ROW_W-1:0] row;
  } mem_hit_t;

  typedef struct packed {
    logic       wr_index;
    logic       wr_sound;
    logic       wr_ctrl;
    logic [7:0] data;
  } reg_wr_t;

  typedef struct packed {
    logic graphics_bank;
    logic color_bank;
    logic paddle_sel;
  } ctrl_t;

  function automatic mem_hit_t decode_mem(input logic [15:0] a);
    mem_hit_t h;
    logic [15:0] ofs;
    h   = '{hit: 1'b0, lane: LANE_WORK, row: '0};
    ofs = a - ADDR_EXTRA_BASE;
    if (a[15:11] == WORK_PAGE) begin
      h = '{hit: 1'b1, lane: LANE_WORK, row: a[ROW_W-1:0]};
    end else if (a[15:11] == VIDEO_PAGE) begin
      h = '{hit: 1'b1, lane: LANE_VIDEO, row: a[ROW_W-1:0]};
    end else if (a[15:6] == SPRITE_PAGE) begin
      h = '{hit: 1'b1, lane: LANE_SPRITE, row: ROW_W'(a[SPR_W-1:0])};
    end else if (a >= ADDR_EXTRA_BASE && a <= ADDR_EXTRA_LAST) begin
      h = '{hit: 1'b1, lane: LANE_EXTRA, row: ofs[ROW_W-1:0]};
    end
    return h;
  endfunction

  function automatic logic [7:0] paddle_sat(input logic signed [15:0] p);
    logic [7:0] v;
    if (p[15]) begin
      v = 8'h00;
    end else if (p[14:8] != 7'd0) begin
      v = 8'hFF;
    end else begin
      v = p[7:0];
    end
    return v;
  endfunction

endpackage

// File: src/abad_mem.sv
// Shared byte-lane RAM for work, video, extra and sprite RAM, with post-reset clear sweep.
module abad_mem (
  input  logic              clk,
  input  logic              rst,
  input  abad_pkg::mem_req_t req,
  output logic [31:0]       rdata,
  output logic              clearing
);
  import abad_pkg::*;

  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(RAM_BYTES - 1);

  logic [31:0]      mem [RAM_BYTES];
  logic [ROW_W-1:0] clear_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clear_row <= '0;
    end else if (clearing) begin
      clear_row <= clear_row + 1'b1;
      if (clear_row == ROW_LAST) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clear_row] <= '0;
    end else if (req.wr) begin
      for (int b = 0; b < LANES; b++) begin
        if (req.lane == lane_t'(b)) begin
          mem[req.row][8*b +: 8] <= req.data;
        end
      end
    end
    if (req.rd) begin
      rdata <= mem[req.row];
    end
  end

endmodule

// File: src/abad_regs.sv
// Sound-chip index latch, sound registers and video control latch.
module abad_regs (
  input  logic             clk,
  input  logic             rst,
  input  abad_pkg::reg_wr_t wr,
  input  logic [7:0]       dip,
  output logic [7:0]       sound_rd,
  output abad_pkg::ctrl_t  ctrl
);
  import abad_pkg::*;

  logic [3:0] sound_index;
  logic [7:0] sound_regs [16];

  always_ff @(posedge clk) begin
    if (rst) begin
      sound_index <= '0;
      ctrl        <= '0;
      for (int i = 0; i < 16; i++) begin
        sound_regs[i] <= '0;
      end
    end else begin
      if (wr.wr_index) begin
        sound_index <= wr.data[3:0];
      end
      if (wr.wr_sound && sound_index < SOUND_PORT_FIRST) begin
        sound_regs[sound_index] <= wr.data;
      end
      if (wr.wr_ctrl) begin
        ctrl <= '{graphics_bank: wr.data[5], color_bank: wr.data[6], paddle_sel: wr.data[2]};
      end
    end
  end

  assign sound_rd = (sound_index >= SOUND_PORT_FIRST) ? dip : sound_regs[sound_index];

endmodule

// File: src/arcade_bus_address_decoder_unit.sv
// Top level: CPU bus access decoder for the arcade board memory map.
//
// Input stream (s_*): one bus access per transfer; s_tuser is the operation
// (0 read, 1 write), s_tdata carries address, write data, buttons and paddle.
// Output stream (m_*): one result per access; s_tuser-style flag m_tuser marks
// a ROM read, m_tdata carries read data and the three control latch bits.
// APB port: register 0 (byte address 0) is the DIP switch value, reset 0xFF.
//
// The access is decoded and the RAM read at the input transfer edge into the
// pending stage; the result register loads from it once the output is free,
// and m_tvalid rises with it. One access per cycle is sustained while m_tready
// is high; the single-port RAM serves one read or one byte write per access.
// After reset a clear sweep zeroes all 2048 RAM rows, one row per cycle;
// s_tready stays low during it. APB writes are taken at any time.
// When m_tready is low the result holds, one further access is taken into
// the pending stage, and then s_tready drops until the result is taken.
module arcade_bus_address_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // address[15:0], write_data[23:16], buttons[26:24], paddle[42:27]
  input  logic        s_tuser,   // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // read_data[7:0], graphics_bank, color_bank, paddle_sel
  output logic        m_tuser,   // rom_access
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import abad_pkg::*;

  logic               op_wr;
  logic [15:0]        address;
  logic [7:0]         write_data;
  logic [2:0]         buttons;
  logic signed [15:0] paddle_position;

  logic       accept;
  logic       move;
  logic       clearing;
  logic [7:0] dip;
  logic [7:0] sound_rd;
  ctrl_t      ctrl;
  mem_hit_t   hit;
  mem_req_t   req;
  reg_wr_t    reg_wr;
  logic [31:0] rdata;
  logic [7:0] fixed;
  logic [7:0] lane_byte;
  logic [7:0] rd_byte;

  logic       pend_valid;
  logic       pend_is_mem;
  lane_t      pend_lane;
  logic [7:0] pend_fixed;
  logic       pend_rom;

  assign op_wr           = s_tuser;
  assign address         = s_tdata[15:0];
  assign write_data      = s_tdata[23:16];
  assign buttons         = s_tdata[26:24];
  assign paddle_position = s_tdata[42:27];

  assign move     = pend_valid && (!m_tvalid || m_tready);
  assign s_tready = !rst && !clearing && (!pend_valid || move);
  assign accept   = s_tvalid && s_tready;

  assign hit = decode_mem(address);

  always_comb begin
    req      = '{rd: 1'b0, wr: 1'b0, row: hit.row, lane: hit.lane, data: write_data};
    req.rd   = accept && !op_wr && hit.hit;
    req.wr   = accept && op_wr && hit.hit;
    reg_wr.data     = write_data;
    reg_wr.wr_index = accept && op_wr && address == ADDR_SOUND_INDEX;
    reg_wr.wr_sound = accept && op_wr && address == ADDR_SOUND_DATA;
    reg_wr.wr_ctrl  = accept && op_wr && address == ADDR_CONTROL;
  end

  always_comb begin
    case (address)
      ADDR_SOUND_DATA: fixed = sound_rd;
      ADDR_CONTROL:    fixed = 8'h00;
      ADDR_SYSTEM:     fixed = {SYSTEM_IDLE[7:5], buttons[0], SYSTEM_IDLE[3:1], !buttons[1]};
      ADDR_FIRE:       fixed = {OPEN_BUS[7:1], !buttons[2]};
      ADDR_PADDLE:     fixed = paddle_sat(paddle_position);
      ADDR_ZERO_A:     fixed = 8'h00;
      ADDR_ZERO_B:     fixed = 8'h00;
      default:         fixed = OPEN_BUS;
    endcase
  end

  abad_mem u_mem (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rdata    (rdata),
    .clearing (clearing)
  );

  abad_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr       (reg_wr),
    .dip      (dip),
    .sound_rd (sound_rd),
    .ctrl     (ctrl)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
      dip        <= 8'hFF;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == CFG_DIP_SWITCHES) begin
        dip <= pwdata[7:0];
      end
      if (accept) begin
        pend_valid <= 1'b1;
      end else if (move) begin
        pend_valid <= 1'b0;
      end
      if (move) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_comb begin
    case (pend_lane)
      LANE_WORK:   lane_byte = rdata[7:0];
      LANE_VIDEO:  lane_byte = rdata[15:8];
      LANE_EXTRA:  lane_byte = rdata[23:16];
      LANE_SPRITE: lane_byte = rdata[31:24];
      default:     lane_byte = rdata[7:0];
    endcase
    rd_byte = pend_is_mem ? lane_byte : pend_fixed;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_is_mem <= !op_wr && hit.hit && address >= ADDR_ROM_TOP;
      pend_lane   <= hit.lane;
      pend_rom    <= !op_wr && address < ADDR_ROM_TOP;
      pend_fixed  <= (op_wr || address < ADDR_ROM_TOP) ? 8'h00 : fixed;
    end
    if (move) begin
      m_tdata <= {5'b0, ctrl.paddle_sel, ctrl.color_bank, ctrl.graphics_bank, rd_byte};
      m_tuser <= pend_rom;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == CFG_DIP_SWITCHES) ? {24'b0, dip} : 32'b0;

endmodule

// File: src/abad_check.sv
// Port-level checks for the bus address decoder, bound to the top level.
module abad_check (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser
);

  a_clear_blocks_input: assert property (@(posedge clk) $past(rst) |-> !s_tready)
    else $error("input taken during RAM clear");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_rom_reads_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[7:0] == 8'h00)
    else $error("ROM access with nonzero read data");

  a_two_cycle_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) ##1 m_tready |=> m_tvalid)
    else $error("result missing two cycles after transfer");

endmodule

bind arcade_bus_address_decoder_unit abad_check u_abad_check (.*);

// File: tb/testbench.sv
// Self-checking testbench for the arcade bus address decoder: directed table plus random traffic.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import abad_pkg::*;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  localparam logic [15:0] WORK_LAST   = 16'hC7FF;
  localparam logic [15:0] VIDEO_BASE  = 16'hE000;
  localparam logic [15:0] VIDEO_LAST  = 16'hE7FF;
  localparam logic [15:0] SPRITE_BASE = 16'hE800;
  localparam logic [15:0] SPRITE_LAST = 16'hE83F;
  localparam logic [2:0]  DIP_PADDR   = {CFG_DIP_SWITCHES, 2'b00};
  localparam int          PHASES      = 6;
  localparam int          PHASE_ITEMS = 284;

  typedef struct packed {
    op_e                op;
    logic [15:0]        addr;
    logic [7:0]         wdata;
    logic [2:0]         btn;
    logic signed [15:0] paddle;
  } bus_access_t;

  typedef struct packed {
    logic [7:0] rd;
    logic       rom;
    logic       graphics_bank;
    logic       colour_bank;
    logic       paddle_sel;
  } bus_result_t;

  typedef struct {
    bus_access_t acc;
    int          exp_rd;
    bit          exp_rom;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // address[15:0], write_data[23:16], buttons[26:24], paddle[42:27]
  logic        s_tuser = 1'b0; // operation
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // read_data[7:0], graphics_bank, colour_bank, paddle_sel
  logic        m_tuser;        // rom_access
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  arcade_bus_address_decoder_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // board state mirror
  logic [7:0] work_mem   [RAM_BYTES];
  logic [7:0] video_mem  [RAM_BYTES];
  logic [7:0] extra_mem  [RAM_BYTES];
  logic [7:0] sprite_mem [SPRITE_RAM_BYTES];
  logic [7:0] tone_regs  [16];
  logic [3:0] tone_index;
  logic       bank_gfx, bank_pal, paddle_sel_q;
  logic [7:0] dip_value;

  bus_result_t pending_results[$];
  plan_row_t   directed_plan[$];
  int          fails = 0;
  bit          no_idle = 1'b0;
  int          stall_left = 0;

  function automatic bus_result_t decode_access(input bus_access_t acc);
    bus_result_t r;
    logic [15:0] a, ofs;
    logic [7:0]  v;
    r   = '0;
    a   = acc.addr;
    ofs = a - ADDR_EXTRA_BASE;
    if (acc.op == OP_WRITE) begin
      if (a >= ADDR_ROM_TOP && a <= WORK_LAST) begin
        work_mem[a[10:0]] = acc.wdata;
      end else if (a == ADDR_SOUND_INDEX) begin
        tone_index = acc.wdata[3:0];
      end else if (a == ADDR_SOUND_DATA) begin
        if (tone_index < SOUND_PORT_FIRST) tone_regs[tone_index] = acc.wdata;
      end else if (a == ADDR_CONTROL) begin
        bank_gfx     = acc.wdata[5];
        bank_pal     = acc.wdata[6];
        paddle_sel_q = acc.wdata[2];
      end else if (a >= VIDEO_BASE && a <= VIDEO_LAST) begin
        video_mem[a[10:0]] = acc.wdata;
      end else if (a >= SPRITE_BASE && a <= SPRITE_LAST) begin
        sprite_mem[a[5:0]] = acc.wdata;
      end else if (a >= ADDR_EXTRA_BASE && a <= ADDR_EXTRA_LAST) begin
        extra_mem[ofs[10:0]] = acc.wdata;
      end
    end else if (a < ADDR_ROM_TOP) begin
      r.rom = 1'b1;
    end else begin
      if (a <= WORK_LAST) begin
        v = work_mem[a[10:0]];
      end else if (a == ADDR_SOUND_DATA) begin
        v = (tone_index >= SOUND_PORT_FIRST) ? dip_value : tone_regs[tone_index];
      end else if (a == ADDR_CONTROL) begin
        v = 8'h00;
      end else if (a == ADDR_SYSTEM) begin
        v = SYSTEM_IDLE;
        if (acc.btn[0]) v = v | 8'h10;
        if (acc.btn[1]) v[0] = 1'b0;
      end else if (a == ADDR_FIRE) begin
        v = 8'hFF;
        v[0] = ~acc.btn[2];
      end else if (a == ADDR_PADDLE) begin
        if (acc.paddle < 0) v = 8'h00;
        else if (acc.paddle > 16'sd255) v = 8'hFF;
        else v = acc.paddle[7:0];
      end else if (a >= VIDEO_BASE && a <= VIDEO_LAST) begin
        v = video_mem[a[10:0]];
      end else if (a >= SPRITE_BASE && a <= SPRITE_LAST) begin
        v = sprite_mem[a[5:0]];
      end else if (a >= ADDR_EXTRA_BASE && a <= ADDR_EXTRA_LAST) begin
        v = extra_mem[ofs[10:0]];
      end else if (a == ADDR_ZERO_A || a == ADDR_ZERO_B) begin
        v = 8'h00;
      end else begin
        v = OPEN_BUS;
      end
      r.rd = v;
    end
    r.graphics_bank = bank_gfx;
    r.colour_bank   = bank_pal;
    r.paddle_sel    = paddle_sel_q;
    return r;
  endfunction

  function automatic void add_row(input op_e op, input logic [15:0] addr,
                                  input logic [7:0] wdata, input logic [2:0] btn,
                                  input logic signed [15:0] paddle,
                                  input int exp_rd, input bit exp_rom);
    plan_row_t row;
    row.acc     = '{op: op, addr: addr, wdata: wdata, btn: btn, paddle: paddle};
    row.exp_rd  = exp_rd;
    row.exp_rom = exp_rom;
    directed_plan.push_back(row);
  endfunction

  // mostly the first rows so that reads find earlier writes
  function automatic logic [15:0] pick_row(input int n);
    int r;
    if ($urandom_range(0, 3) != 0) r = $urandom_range(0, 15);
    else if ($urandom_range(0, 3) == 0) r = n - 1 - $urandom_range(0, 3);
    else r = $urandom_range(0, n - 1);
    return 16'(r);
  endfunction

  function automatic bus_access_t random_access();
    bus_access_t acc;
    logic [15:0] a;
    acc.op     = ($urandom_range(0, 1) != 0) ? OP_WRITE : OP_READ;
    acc.wdata  = 8'($urandom);
    acc.btn    = 3'($urandom_range(0, 7));
    acc.paddle = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 300)) : 16'($urandom);
    case ($urandom_range(0, 15))
      0:       a = 16'($urandom_range(0, 32'(ADDR_ROM_TOP) - 1));
      1, 2:    a = ADDR_ROM_TOP + pick_row(RAM_BYTES);
      3, 4:    a = VIDEO_BASE + pick_row(RAM_BYTES);
      5:       a = SPRITE_BASE + pick_row(SPRITE_RAM_BYTES);
      6, 7:    a = ADDR_EXTRA_BASE + pick_row(32'(ADDR_EXTRA_LAST - ADDR_EXTRA_BASE) + 1);
      8:       a = ADDR_SOUND_INDEX;
      9, 10:   a = ADDR_SOUND_DATA;
      11:      a = ADDR_CONTROL;
      12: begin
        case ($urandom_range(0, 2))
          0:       a = ADDR_SYSTEM;
          1:       a = ADDR_FIRE;
          default: a = ADDR_PADDLE;
        endcase
      end
      13:      a = ADDR_ZERO_A + 16'($urandom_range(0, 3));
      14:      a = 16'($urandom);
      default: a = ADDR_SOUND_INDEX + 16'($urandom_range(0, 31));
    endcase
    acc.addr = a;
    return acc;
  endfunction

  function automatic int pick_gap();
    int g;
    g = 0;
    if (!no_idle) begin
      case ($urandom_range(0, 9))
        6, 7, 8: g = $urandom_range(1, 3);
        9:       g = $urandom_range(8, 40);
        default: g = 0;
      endcase
    end
    return g;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    fails++;
    if (fails <= 10) $display("mismatch %s: expected %h, got %h", what, want, got);
  endtask

  task automatic issue(input bus_access_t acc, input bit use_typed, input bus_result_t typed);
    bus_result_t predicted;
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= acc.op;
    s_tdata  <= {5'b0, acc.paddle, acc.btn, acc.wdata, acc.addr};
    do @(posedge clk); while (!s_tready);
    predicted = decode_access(acc);
    pending_results.push_back(use_typed ? typed : predicted);
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // write the DIP register, then read it back
  task automatic set_dip(input logic [7:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= DIP_PADDR;
    pwdata  <= {24'b0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    dip_value = v;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {24'b0, v}) report_mismatch("dip readback", {24'b0, v}, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 4) == 0) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    bus_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{rd: m_tdata[7:0], rom: m_tuser, graphics_bank: m_tdata[8],
              colour_bank: m_tdata[9], paddle_sel: m_tdata[10]};
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transfer", '0, 32'(got));
      end else begin
        want = pending_results.pop_front();
        if (got.rd !== want.rd || got.rom !== want.rom ||
            got.graphics_bank !== want.graphics_bank ||
            got.colour_bank !== want.colour_bank || got.paddle_sel !== want.paddle_sel)
          report_mismatch("result {rd,rom,gfx,colour,paddle}", 32'(want), 32'(got));
      end
    end
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    bus_result_t typed;
    logic [7:0]  dips [PHASES];
    foreach (work_mem[i]) begin
      work_mem[i]  = '0;
      video_mem[i] = '0;
      extra_mem[i] = '0;
    end
    foreach (sprite_mem[i]) sprite_mem[i] = '0;
    foreach (tone_regs[i]) tone_regs[i] = '0;
    tone_index   = '0;
    bank_gfx     = 1'b0;
    bank_pal     = 1'b0;
    paddle_sel_q = 1'b0;
    dip_value    = 8'hFF;

    // typed rows come before any control write, so the latch bits are zero
    add_row(OP_READ,  16'h0000,         8'h00, 3'd0,   16'sd0,      8'h00, 1'b1);
    add_row(OP_READ,  16'hBFFF,         8'hFF, 3'd7,   -16'sd1,     8'h00, 1'b1);
    add_row(OP_READ,  WORK_LAST,        8'h00, 3'd0,   16'sd0,      8'h00, 1'b0);
    add_row(OP_READ,  ADDR_SYSTEM,      8'h00, 3'b000, 16'sd0,      8'h4F, 1'b0);
    add_row(OP_READ,  ADDR_SYSTEM,      8'h00, 3'b111, 16'sd0,      8'h5E, 1'b0);
    add_row(OP_READ,  ADDR_FIRE,        8'h00, 3'b100, 16'sd0,      8'hFE, 1'b0);
    add_row(OP_READ,  ADDR_PADDLE,      8'h00, 3'd0,   16'sh8000,   8'h00, 1'b0);
    add_row(OP_READ,  ADDR_PADDLE,      8'h00, 3'd0,   16'sh7FFF,   8'hFF, 1'b0);
    add_row(OP_READ,  ADDR_PADDLE,      8'h00, 3'd0,   16'sd255,    8'hFF, 1'b0);
    add_row(OP_READ,  16'hFFFF,         8'h00, 3'd0,   16'sd0,      8'hFF, 1'b0);
    add_row(OP_READ,  ADDR_ZERO_B,      8'h00, 3'd0,   16'sd0,      8'h00, 1'b0);
    add_row(OP_READ,  ADDR_SOUND_DATA,  8'h00, 3'd0,   16'sd0,      8'h00, 1'b0);
    add_row(OP_WRITE, ADDR_SOUND_INDEX, 8'hFE, 3'd0,   16'sd0,      -1,    1'b0);
    add_row(OP_WRITE, ADDR_SOUND_DATA,  8'h33, 3'd0,   16'sd0,      -1,    1'b0);
    add_row(OP_READ,  ADDR_SOUND_DATA,  8'h00, 3'd0,   16'sd0,      -1,    1'b0);
    add_row(OP_WRITE, ADDR_SOUND_INDEX, 8'h0D, 3'd0,   16'sd0,      -1,    1'b0);
    add_row(OP_WRITE, ADDR_SOUND_DATA,  8'hA5, 3'd0,   16'sd0,      -1,    1'b0);
    add_row(OP_READ,  ADDR_SOUND_DATA,  8'h00, 3'd0,   16'sd0,      -1,    1'b0);
    add_row(OP_WRITE, ADDR_CONTROL,     8'h64, 3'd0,   16'sd0,      -1,    1'b0);
    add_row(OP_WRITE, SPRITE_LAST,      8'h5A, 3'd0,   16'sd0,      -1,    1'b0);
    add_row(OP_READ,  SPRITE_LAST,      8'h00, 3'd0,   16'sd0,      -1,    1'b0);
    add_row(OP_WRITE, ADDR_EXTRA_LAST,  8'hC3, 3'd0,   16'sd0,      -1,    1'b0);
    add_row(OP_READ,  ADDR_EXTRA_LAST,  8'h00, 3'd0,   16'sd0,      -1,    1'b0);
    add_row(OP_WRITE, 16'h0000,         8'h77, 3'd0,   16'sd0,      -1,    1'b0);
    add_row(OP_WRITE, ADDR_FIRE,        8'h00, 3'd0,   16'sd0,      -1,    1'b0);
    add_row(OP_READ,  ADDR_ROM_TOP,     8'h00, 3'd0,   16'sd0,      -1,    1'b0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_plan[i]) begin
      typed = '{rd: 8'(directed_plan[i].exp_rd), rom: directed_plan[i].exp_rom,
                graphics_bank: 1'b0, colour_bank: 1'b0, paddle_sel: 1'b0};
      issue(directed_plan[i].acc, directed_plan[i].exp_rd >= 0, typed);
    end

    dips[0] = 8'h00;
    dips[1] = 8'hFF;
    for (int p = 2; p < PHASES; p++) dips[p] = 8'($urandom);
    for (int p = 0; p < PHASES; p++) begin
      drain();
      set_dip(dips[p]);
      no_idle = (p == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) issue(random_access(), 1'b0, '0);
    end
    no_idle = 1'b0;

    drain();
    repeat (10) @(posedge clk);
    if (fails == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: arcade_bus_address_decoder_unit.f
src/abad_pkg.sv
src/abad_mem.sv
src/abad_regs.sv
src/arcade_bus_address_decoder_unit.sv
src/abad_check.sv
tb/testbench.sv
